// File: rtl/core/mandelbrot_escape_time_macros.svh
// assertion macros for the mandelbrot escape-time core
// no dependencies; included by files that carry concurrent assertions
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define MBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mandelbrot escape-time check failed");

// next-cycle implication
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mandelbrot escape-time check failed");

`endif

// File: rtl/core/mbe_pkg.sv
// shared types, constants and saturation helper for the escape-time core
// no dependencies
package mbe_pkg;

	localparam int Q_W       = 32;
	localparam int FRAC_W    = 28;
	localparam int CNT_W     = 16;
	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = 12;
	localparam int WIDE_W    = 48;
	localparam int PROD_W    = 2 * Q_W;
	localparam int IDX_W     = 2;

	typedef logic signed [Q_W-1:0]    q_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [COL_W-1:0]         col_t;
	typedef logic [IDX_W-1:0]         reg_idx_t;

	// register indexes on the write port
	localparam reg_idx_t REG_LEFT_EDGE      = 2'd0;
	localparam reg_idx_t REG_STEP_REAL      = 2'd1;
	localparam reg_idx_t REG_MAX_ITERATIONS = 2'd2;

	localparam q_t     LEFT_EDGE_RST = -32'sd536870912;
	localparam q_t     STEP_REAL_RST = 32'sd1048576;
	localparam count_t MAX_ITER_RST  = 16'd255;

	localparam col_t  COL_LIMIT  = COL_W'(MAX_WIDTH - 1);
	// 4.0 in the scale of x*x >> 28
	localparam wide_t BOUND_FOUR = 48'sd1 << 30;
	localparam wide_t Q_MAX_W    = 48'sd2147483647;
	localparam wide_t Q_MIN_W    = -48'sd2147483648;

	function automatic q_t sat_q(wide_t v);
		q_t r;
		if (v > Q_MAX_W) begin
			r = q_t'(Q_MAX_W);
		end else if (v < Q_MIN_W) begin
			r = q_t'(Q_MIN_W);
		end else begin
			r = q_t'(v);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/mandelbrot_escape_time.sv
// one shared 32x32 signed multiplier does col*step, then x*x, y*y, x*y in turn per iteration
// next item accepted in the cycle done is high
// done is a one-cycle strobe, the receiver cannot stall it
// arst_n clears the sequencer and loads register defaults (-2.0, 2^-8, 255)
// depends on mbe_pkg and mandelbrot_escape_time_macros.svh
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              write_enable,
	input  mbe_pkg::reg_idx_t write_index,
	input  mbe_pkg::q_t       write_data,
	input  logic              start,
	output logic              busy,
	input  mbe_pkg::col_t     column,
	input  mbe_pkg::q_t       imag_part,
	output logic              done,
	output mbe_pkg::count_t   iteration_count,
	output logic              reached_limit
);
	import mbe_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CR    = 3'd1;
	localparam logic [2:0] S_CRADD = 3'd2;
	localparam logic [2:0] S_XX    = 3'd3;
	localparam logic [2:0] S_YY    = 3'd4;
	localparam logic [2:0] S_XY    = 3'd5;
	localparam logic [2:0] S_UPD   = 3'd6;

	logic [2:0] state_q;
	logic       done_q;
	count_t     count_q;

	q_t     left_edge_q;
	q_t     step_real_q;
	count_t max_iter_q;

	col_t   col_q;
	q_t     ci_q;
	q_t     cr_q;
	q_t     x_q;
	q_t     y_q;
	wide_t  xx_q;
	wide_t  yy_q;
	prod_t  prod_q;
	count_t result_cnt_q;
	logic   result_lim_q;

	q_t     mul_a;
	q_t     mul_b;
	prod_t  mul_p;
	prod_t  sh_frac;
	prod_t  sh_twice;
	wide_t  mag_sq;
	logic   escape;
	count_t count_inc;
	logic   finish;
	count_t final_cnt;

	// operand select for the shared multiplier
	always_comb begin
		unique case (state_q)
			S_CR: begin
				mul_a = q_t'({{(Q_W - COL_W){1'b0}}, col_q});
				mul_b = step_real_q;
			end
			S_XX: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			S_YY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = x_q;
				mul_b = y_q;
			end
		endcase
	end

	assign mul_p     = mul_a * mul_b;
	assign sh_frac   = prod_q >>> FRAC_W;
	assign sh_twice  = prod_q >>> (FRAC_W - 1);
	assign mag_sq    = xx_q + yy_q;
	assign escape    = (mag_sq >= BOUND_FOUR);
	assign count_inc = count_q + count_t'(1);

	always_comb begin
		finish    = 1'b0;
		final_cnt = count_q;
		if (state_q == S_CRADD && max_iter_q == '0) begin
			finish = 1'b1;
		end else if (state_q == S_UPD) begin
			if (escape) begin
				finish = 1'b1;
			end else if (count_inc == max_iter_q) begin
				finish    = 1'b1;
				final_cnt = count_inc;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_edge_q <= LEFT_EDGE_RST;
			step_real_q <= STEP_REAL_RST;
			max_iter_q  <= MAX_ITER_RST;
		end else if (write_enable) begin
			unique case (write_index)
				REG_LEFT_EDGE:      left_edge_q <= write_data;
				REG_STEP_REAL:      step_real_q <= write_data;
				REG_MAX_ITERATIONS: max_iter_q  <= count_t'(write_data[CNT_W-1:0]);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= finish;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CR;
						count_q <= '0;
					end
				end
				S_CR:    state_q <= S_CRADD;
				S_CRADD: state_q <= finish ? S_IDLE : S_XX;
				S_XX:    state_q <= S_YY;
				S_YY:    state_q <= S_XY;
				S_XY:    state_q <= S_UPD;
				S_UPD: begin
					if (finish) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_XX;
					end
					if (!escape) begin
						count_q <= count_inc;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == S_IDLE && start) begin
			col_q <= (column > COL_LIMIT) ? COL_LIMIT : column;
			ci_q  <= imag_part;
			x_q   <= '0;
			y_q   <= '0;
		end
		if (state_q == S_CRADD) begin
			cr_q <= sat_q(wide_t'(prod_q[WIDE_W-1:0]) + wide_t'(left_edge_q));
		end
		if (state_q == S_YY) begin
			xx_q <= wide_t'(sh_frac[WIDE_W-1:0]);
		end
		if (state_q == S_XY) begin
			yy_q <= wide_t'(sh_frac[WIDE_W-1:0]);
		end
		if (state_q == S_UPD && !escape) begin
			x_q <= sat_q(xx_q - yy_q + wide_t'(cr_q));
			y_q <= sat_q(wide_t'(sh_twice[WIDE_W-1:0]) + wide_t'(ci_q));
		end
		if (finish) begin
			result_cnt_q <= final_cnt;
			result_lim_q <= (final_cnt == max_iter_q);
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign iteration_count = result_cnt_q;
	assign reached_limit   = result_lim_q;

	`MBE_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`MBE_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`MBE_ASSERT_NEXT(a_done_strobe, clk, arst_n, done, !done)
	`MBE_ASSERT_IMP(a_fall_done, clk, arst_n, $fell(busy), done)

endmodule

// File: test/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// self-checking testbench for the mandelbrot escape-time counter
// predicts iteration count and limit flag per pixel; depends on mbe_pkg and the dut only
module tb_mandelbrot_escape_time;
	import mbe_pkg::*;

	localparam int       CLK_HALF    = 2;
	localparam reg_idx_t REG_UNUSED  = 2'd3;
	localparam q_t       Q_TWO       = 32'sh2000_0000;
	localparam q_t       Q_NEG_TWO   = -32'sh2000_0000;
	localparam q_t       Q_ONE       = 32'sh1000_0000;
	localparam q_t       Q_TOP       = 32'sh7fff_ffff;
	localparam q_t       Q_BOTTOM    = 32'sh8000_0000;
	localparam longint   SCALED_FOUR = 64'sd1 <<< 30;
	localparam longint   Q_HIGH      = 64'sd2147483647;
	localparam longint   Q_LOW       = -64'sd2147483648;

	typedef struct packed {
		count_t count;
		logic   at_limit;
	} pixel_result_t;

	logic     clk;
	logic     arst_n;
	logic     write_enable;
	reg_idx_t write_index;
	q_t       write_data;
	logic     start;
	logic     busy;
	col_t     column;
	q_t       imag_part;
	logic     done;
	count_t   iteration_count;
	logic     reached_limit;

	// shadow of the block's registers
	q_t     cfg_left_edge = LEFT_EDGE_RST;
	q_t     cfg_step_real = STEP_REAL_RST;
	count_t cfg_max_iter  = MAX_ITER_RST;

	pixel_result_t pending_pixels[$];
	int            mismatch_count = 0;
	int            idle_pct = 0;

	mandelbrot_escape_time dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.write_enable    (write_enable),
		.write_index     (write_index),
		.write_data      (write_data),
		.start           (start),
		.busy            (busy),
		.column          (column),
		.imag_part       (imag_part),
		.done            (done),
		.iteration_count (iteration_count),
		.reached_limit   (reached_limit)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#16_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic longint clamp_q(longint v);
		longint r;
		r = v;
		if (v > Q_HIGH) begin
			r = Q_HIGH;
		end else if (v < Q_LOW) begin
			r = Q_LOW;
		end
		return r;
	endfunction

	function automatic pixel_result_t predict_escape_time(col_t col, q_t ci_q);
		longint        cr;
		longint        ci;
		longint        x;
		longint        y;
		longint        xx;
		longint        yy;
		longint        two_xy;
		int unsigned   n;
		logic          escaped;
		pixel_result_t r;
		cr = clamp_q(longint'(cfg_left_edge) + longint'(col) * longint'(cfg_step_real));
		ci = longint'(ci_q);
		x = 0;
		y = 0;
		n = 0;
		escaped = 1'b0;
		while (!escaped && n < cfg_max_iter) begin
			xx = (x * x) >>> FRAC_W;
			yy = (y * y) >>> FRAC_W;
			// landing exactly on |z|^2 == 4 counts as escaped
			if (xx + yy >= SCALED_FOUR) begin
				escaped = 1'b1;
			end else begin
				two_xy = (x * y) >>> (FRAC_W - 1);
				x = clamp_q(xx - yy + cr);
				y = clamp_q(two_xy + ci);
				n++;
			end
		end
		r.count = count_t'(n);
		r.at_limit = (n == cfg_max_iter);
		return r;
	endfunction

	// mostly rows through the interesting band, some anywhere in range
	function automatic q_t random_imag();
		if ($urandom_range(99) < 15) begin
			return q_t'($urandom);
		end
		return q_t'(int'($urandom_range(671_088_640)) - 335_544_320);
	endfunction

	always @(negedge clk) begin : check_results
		pixel_result_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: result with no item pending: count %0d limit %0b",
					$time, iteration_count, reached_limit);
				mismatch_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (iteration_count !== want.count) begin
					$display("%0t: iteration_count expected %0d actual %0d",
						$time, want.count, iteration_count);
					mismatch_count++;
				end
				if (reached_limit !== want.at_limit) begin
					$display("%0t: reached_limit expected %0b actual %0b",
						$time, want.at_limit, reached_limit);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_pixel(col_t col, q_t ci_q);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			column <= col_t'($urandom);
			imag_part <= q_t'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		column <= col;
		imag_part <= ci_q;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (!busy) begin
				taken = 1'b1;
				pending_pixels.push_back(predict_escape_time(col, ci_q));
			end
			@(posedge clk);
		end
	endtask

	task automatic write_register(reg_idx_t idx, q_t data);
		write_enable <= 1'b1;
		write_index <= idx;
		write_data <= data;
		@(posedge clk);
		write_enable <= 1'b0;
		case (idx)
			REG_LEFT_EDGE: begin
				cfg_left_edge = data;
			end
			REG_STEP_REAL: begin
				cfg_step_real = data;
			end
			REG_MAX_ITERATIONS: begin
				cfg_max_iter = data[CNT_W-1:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic set_view(q_t left, q_t step, count_t limit);
		write_register(REG_LEFT_EDGE, left);
		write_register(REG_STEP_REAL, step);
		// upper data bits are don't-care for the 16-bit limit
		write_register(REG_MAX_ITERATIONS, q_t'({16'($urandom), limit}));
	endtask

	task automatic wait_idle(int settle);
		start <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (settle) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		idle_pct = 0;
		send_pixel(col_t'(512), '0);
		send_pixel(col_t'(128), '0);
		send_pixel(COL_LIMIT, Q_TOP);
		send_pixel(COL_LIMIT, Q_BOTTOM);
		send_pixel(col_t'(2048), Q_ONE);
		send_pixel(col_t'(448), q_t'(32'sh0400_0000));
		wait_idle(8);
	endtask

	task automatic test_escape_bound();
		// c = -2 lands exactly on the bound after one step
		set_view(Q_NEG_TWO, STEP_REAL_RST, MAX_ITER_RST);
		send_pixel('0, '0);
		wait_idle(8);
		write_register(REG_LEFT_EDGE, '0);
		send_pixel('0, Q_TWO);
		send_pixel('0, Q_NEG_TWO);
		send_pixel('0, Q_TWO - 1);
		wait_idle(8);
	endtask

	task automatic test_real_saturation();
		set_view(Q_TOP, Q_TOP, MAX_ITER_RST);
		send_pixel('0, '0);
		send_pixel(COL_LIMIT, '0);
		wait_idle(8);
		set_view(Q_BOTTOM, Q_BOTTOM, MAX_ITER_RST);
		send_pixel(COL_LIMIT, Q_ONE);
		wait_idle(8);
		// zero step: every column maps to c = -1, a period-two orbit
		set_view(-Q_ONE, '0, count_t'(40));
		send_pixel(col_t'($urandom), '0);
		wait_idle(8);
	endtask

	task automatic test_iteration_limits();
		set_view(Q_NEG_TWO, STEP_REAL_RST, '0);
		send_pixel(col_t'(512), '0);
		send_pixel(COL_LIMIT, q_t'($urandom));
		wait_idle(8);
		write_register(REG_MAX_ITERATIONS, q_t'(1));
		// write to an unmapped index must leave all registers alone
		write_register(REG_UNUSED, q_t'($urandom));
		send_pixel(col_t'(512), '0);
		send_pixel('0, '0);
		wait_idle(8);
		write_register(REG_MAX_ITERATIONS, q_t'(32'hffff_ffff));
		send_pixel('0, '0);
		send_pixel(col_t'(600), Q_ONE);
		send_pixel(col_t'(1000), '0);
		send_pixel(COL_LIMIT, '0);
		wait_idle(8);
	endtask

	task automatic run_random_sweep(int n_items, int idle);
		idle_pct = idle;
		repeat (n_items) begin
			send_pixel(col_t'($urandom), random_imag());
		end
		wait_idle(8);
	endtask

	task automatic test_random_sweeps();
		// full view of the set, default limit
		set_view(Q_NEG_TWO, q_t'(196608), MAX_ITER_RST);
		run_random_sweep(120, 0);
		// jittered view, short limits, sender mostly idle
		set_view(Q_NEG_TWO + q_t'(int'($urandom_range(134_217_728)) - 67_108_864),
			q_t'($urandom_range(262_144)), count_t'($urandom_range(1, 64)));
		run_random_sweep(170, 87);
		// arbitrary registers, real part often saturates
		set_view(q_t'($urandom), q_t'($urandom), count_t'($urandom_range(300)));
		run_random_sweep(170, 0);
		// zoom near the boundary
		set_view(q_t'(-32'sd201326592), q_t'(16384), count_t'(100));
		run_random_sweep(170, 22);
	endtask

	initial begin
		arst_n <= 1'b0;
		write_enable <= 1'b0;
		write_index <= REG_LEFT_EDGE;
		write_data <= '0;
		start <= 1'b0;
		column <= '0;
		imag_part <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_escape_bound();
		test_real_saturation();
		test_iteration_limits();
		test_random_sweeps();
		wait_idle(16);
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
